// ===== hdl/salwc_pkg.sv =====
// ----------------------------------------------------------------------------
// salwc_pkg
// Types and constants of the set-associative LRU write-back cache model.
// ----------------------------------------------------------------------------
package salwc_pkg;

    localparam int MAX_SET_BITS   = 6;
    localparam int MAX_WAYS       = 8;
    localparam int ADDR_W         = 64;
    localparam int BLOCK_BITS_MAX = 12;
    localparam int NUM_SETS       = 1 << MAX_SET_BITS;

    localparam int WAY_W   = 3;
    localparam int RANK_W  = 3;
    localparam int CNT_W   = 32;
    localparam int DBN_W   = 22;
    localparam int DEB_W   = 48;
    localparam int BSIZE_W = BLOCK_BITS_MAX + 1;
    localparam int SHIFT_W = 5;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 176;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        MK_HIT   = 2'd0,
        MK_COLD  = 2'd1,
        MK_EVICT = 2'd2
    } miss_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic                  vld;
        logic                  dty;
        logic [RANK_W-1:0]     rank;
        logic [ADDR_W-1:0]     tag;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] set_row_t;

endpackage

// ===== hdl/set_assoc_lru_writeback_cache_model_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_model_unit
// Flow: the set row is read into a register on accept; the result register is
// loaded by the lookup once the output is free. No new item is taken until then:
// the set-row memory reads the row, then the lookup compares all ways and writes it back.
// Reset: synchronous; per-set valid flops clear at once (no clearing pass),
// counters go to zero, registers to set_bits 0, ways_used 1, block_bits 0.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_model_unit
    import salwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // opcode [0], address [64:1], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // miss_kind [1:0], way_used [4:2], dirty_evicted [5], line_dirtied [6],
    // hit_total [38:7], miss_total [70:39], eviction_total [102:71],
    // dirty_bytes_now [124:103], dirty_evicted_bytes [172:125], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    // configuration
    logic [2:0] set_bits_reg;
    logic [3:0] ways_used_reg;
    logic [3:0] block_bits_reg;
    logic [2:0] sb_eff;
    logic [3:0] ways_eff;
    logic [3:0] bb_eff;

    // control and counters
    state_t                    state_reg, state_next;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      proceed;
    logic [NUM_SETS-1:0]       row_vld_reg;
    logic [CNT_W-1:0]          hits_reg, hits_next;
    logic [CNT_W-1:0]          misses_reg, misses_next;
    logic [CNT_W-1:0]          evicts_reg, evicts_next;
    logic [DBN_W-1:0]          dbytes_reg, dbytes_next;
    logic [DEB_W-1:0]          debytes_reg, debytes_next;

    // item and memory
    logic                      store_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [MAX_SET_BITS-1:0]   set_reg;
    logic [MAX_SET_BITS-1:0]   set_in;
    logic [ADDR_W-1:0]         in_addr;
    set_row_t                  set_mem [NUM_SETS];
    set_row_t                  rd_data_reg;
    set_row_t                  row_wr;

    // lookup results
    miss_kind_t                kind;
    logic [WAY_W-1:0]          way_sel;
    logic                      dev;
    logic                      dirtied;

    assign sb_eff   = (set_bits_reg > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_reg;
    assign ways_eff = (ways_used_reg == 4'd0) ? 4'd1 :
                      ((ways_used_reg > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_used_reg);
    assign bb_eff   = (block_bits_reg > 4'(BLOCK_BITS_MAX)) ? 4'(BLOCK_BITS_MAX)
                                                            : block_bits_reg;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign proceed   = (state_reg == ST_LOOKUP) && (!m_tvalid_reg || m_tready);

    // set index of the incoming item
    assign in_addr = s_tdata[ADDR_W:1];
    always_comb begin
        logic [MAX_SET_BITS:0]          smask;
        logic [BLOCK_BITS_MAX+MAX_SET_BITS-1:0] low;
        smask  = (7'(1) << sb_eff) - 7'(1);
        low    = in_addr[BLOCK_BITS_MAX+MAX_SET_BITS-1:0] >> bb_eff;
        set_in = low[MAX_SET_BITS-1:0] & smask[MAX_SET_BITS-1:0];
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (proceed) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= 3'd0;
            ways_used_reg  <= 4'd1;
            block_bits_reg <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_WAYS_USED:  ways_used_reg  <= cfg_data;
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // set-row memory: read on accept, write back on lookup
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            rd_data_reg <= set_mem[set_in];
            set_reg     <= set_in;
            store_reg   <= s_tdata[0];
            addr_reg    <= in_addr;
        end
        if (proceed) begin
            set_mem[set_reg] <= row_wr;
        end
    end

    // lookup, replacement and counter update
    always_comb begin
        set_row_t              cur;
        logic [ADDR_W-1:0]     tag_cur;
        logic [SHIFT_W-1:0]    shamt;
        logic                  hit_found;
        logic [WAY_W-1:0]      hit_way;
        logic                  free_found;
        logic [WAY_W-1:0]      free_way;
        logic [WAY_W-1:0]      vict;
        logic [RANK_W-1:0]     old_rank;
        logic                  was_valid;
        logic [BSIZE_W-1:0]    bsize;
        logic [DBN_W:0]        dsum;
        logic [DEB_W:0]        esum;

        dsum = '0;
        esum = '0;
        cur = rd_data_reg;
        // a set never written since reset reads as all lines clean and invalid
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!row_vld_reg[set_reg]) begin
                cur[i].vld  = 1'b0;
                cur[i].dty  = 1'b0;
                cur[i].rank = '0;
            end
        end

        shamt   = SHIFT_W'(sb_eff) + SHIFT_W'(bb_eff);
        tag_cur = addr_reg >> shamt;

        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (4'(i) < ways_eff) begin
                if (cur[i].vld && cur[i].tag == tag_cur && !hit_found) begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(i);
                end
                if (!cur[i].vld && !free_found) begin
                    free_found = 1'b1;
                    free_way   = WAY_W'(i);
                end
            end
        end

        // victim: highest rank, lowest way on a tie
        vict = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (4'(i) < ways_eff && cur[i].rank > cur[vict].rank) begin
                vict = WAY_W'(i);
            end
        end

        if (hit_found) begin
            kind    = MK_HIT;
            way_sel = hit_way;
        end else if (free_found) begin
            kind    = MK_COLD;
            way_sel = free_way;
        end else begin
            kind    = MK_EVICT;
            way_sel = vict;
        end

        old_rank  = cur[way_sel].rank;
        was_valid = (kind != MK_COLD);
        dev       = (kind == MK_EVICT) && cur[way_sel].dty;
        dirtied   = (kind == MK_HIT) ? (store_reg && !cur[way_sel].dty) : store_reg;

        // age the other valid ways that were more recent than the touched one (all on a cold fill)
        row_wr = cur;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (4'(i) < ways_eff && WAY_W'(i) != way_sel && cur[i].vld &&
                (!was_valid || cur[i].rank < old_rank) && cur[i].rank != RANK_MAX) begin
                row_wr[i].rank = cur[i].rank + RANK_W'(1);
            end
        end
        row_wr[way_sel].vld  = 1'b1;
        row_wr[way_sel].rank = '0;
        if (kind != MK_HIT) begin
            row_wr[way_sel].tag = tag_cur;
        end
        row_wr[way_sel].dty = (kind == MK_HIT) ? (cur[way_sel].dty || store_reg)
                                               : store_reg;

        bsize = BSIZE_W'(1) << bb_eff;

        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        if (kind == MK_HIT && hits_reg != '1) begin
            hits_next = hits_reg + CNT_W'(1);
        end
        if (kind != MK_HIT && misses_reg != '1) begin
            misses_next = misses_reg + CNT_W'(1);
        end
        if (kind == MK_EVICT && evicts_reg != '1) begin
            evicts_next = evicts_reg + CNT_W'(1);
        end

        dbytes_next  = dbytes_reg;
        debytes_next = debytes_reg;
        if (dev) begin
            dbytes_next = (dbytes_reg > DBN_W'(bsize)) ? dbytes_reg - DBN_W'(bsize) : '0;
            esum        = {1'b0, debytes_reg} + (DEB_W + 1)'(bsize);
            debytes_next = esum[DEB_W] ? '1 : esum[DEB_W-1:0];
        end
        if (dirtied) begin
            dsum        = {1'b0, dbytes_next} + (DBN_W + 1)'(bsize);
            dbytes_next = dsum[DBN_W] ? '1 : dsum[DBN_W-1:0];
        end
    end

    // counters, per-set valid flops and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg  <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            evicts_reg   <= '0;
            dbytes_reg   <= '0;
            debytes_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (proceed) begin
            row_vld_reg[set_reg] <= 1'b1;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            evicts_reg   <= evicts_next;
            dbytes_reg   <= dbytes_next;
            debytes_reg  <= debytes_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            m_tdata_reg <= {3'b000, debytes_next, dbytes_next, evicts_next, misses_next,
                            hits_next, dirtied, dev, way_sel, kind};
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the set-associative LRU write-back cache unit. A
// directed table covers reset state, address extremes, the ignored register
// index and out-of-range geometry; random phases then reconfigure the cache
// and replay clustered load/store traffic. Every result is checked field by
// field against a software cache kept in step with the accepted items.
// ----------------------------------------------------------------------------
module tb_top;
    import salwc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 54;
    localparam int NUM_LINES        = NUM_SETS * MAX_WAYS;

    typedef struct packed {
        miss_kind_t          kind;
        logic [WAY_W-1:0]    way;
        logic                dev;
        logic                dirtied;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
        logic [CNT_W-1:0]    evicts;
        logic [DBN_W-1:0]    dirty_now;
        logic [DEB_W-1:0]    dirty_out;
    } access_result_t;

    typedef struct {
        bit                  is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        logic                store;
        logic [ADDR_W-1:0]   addr;
        bit                  pinned;
        miss_kind_t          kind;
        logic [WAY_W-1:0]    way;
        logic                dev;
        logic                dirtied;
    } step_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    int mismatch_count = 0;

    // software copy of the cache
    logic [2:0]          cur_set_bits = 3'd0;
    logic [3:0]          cur_ways = 4'd1;
    logic [3:0]          cur_block_bits = 4'd0;
    bit                  line_valid_q [NUM_LINES];
    logic [ADDR_W-1:0]   line_tag_q [NUM_LINES];
    bit                  line_dirty_q [NUM_LINES];
    logic [RANK_W-1:0]   line_rank_q [NUM_LINES];
    logic [CNT_W-1:0]    hits_total = '0;
    logic [CNT_W-1:0]    misses_total = '0;
    logic [CNT_W-1:0]    evicts_total = '0;
    logic [DBN_W-1:0]    held_dirty_total = '0;
    logic [DEB_W-1:0]    evicted_dirty_bytes = '0;

    access_result_t pending_results [$];
    step_t          directed_steps [$];

    set_assoc_lru_writeback_cache_model_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("set_assoc_lru_writeback_cache_model_unit: mismatch");
        $finish;
    end

    function automatic void eff_geometry(output int unsigned sb, output int unsigned nw,
                                         output int unsigned bb);
        sb = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
        nw = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
        bb = (cur_block_bits > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : cur_block_bits;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_SET_BITS:   cur_set_bits = val[2:0];
            CFG_WAYS_USED:  cur_ways = val;
            CFG_BLOCK_BITS: cur_block_bits = val;
            default: ;
        endcase
    endfunction

    function automatic void grow_held_dirty(logic [63:0] bsize);
        logic [63:0] sum;
        sum = 64'(held_dirty_total) + bsize;
        held_dirty_total = (sum > 64'h3F_FFFF) ? '1 : sum[DBN_W-1:0];
    endfunction

    function automatic access_result_t cache_lookup(logic store, logic [ADDR_W-1:0] addr);
        int unsigned sb, nw, bb, set_idx, base, way, free_way, old_rank, k;
        logic [ADDR_W-1:0] tag;
        logic [63:0] bsize, sum;
        bit found, have_free, was_valid;
        access_result_t r;
        eff_geometry(sb, nw, bb);
        tag = addr >> (sb + bb);
        set_idx = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
        base = set_idx * MAX_WAYS;
        bsize = 64'd1 << bb;
        r = '0;
        found = 1'b0;
        have_free = 1'b0;
        way = 0;
        free_way = 0;
        for (int i = 0; i < nw; i++) begin
            k = base + i;
            if (line_valid_q[k] && line_tag_q[k] == tag) begin
                found = 1'b1;
                way = i;
                break;
            end
            if (!line_valid_q[k] && !have_free) begin
                have_free = 1'b1;
                free_way = i;
            end
        end
        if (found) begin
            r.kind = MK_HIT;
            k = base + way;
            if (hits_total != '1) hits_total++;
            if (store && !line_dirty_q[k]) begin
                line_dirty_q[k] = 1'b1;
                grow_held_dirty(bsize);
                r.dirtied = 1'b1;
            end
            was_valid = 1'b1;
        end else if (have_free) begin
            r.kind = MK_COLD;
            way = free_way;
            k = base + way;
            line_valid_q[k] = 1'b1;
            line_tag_q[k] = tag;
            line_dirty_q[k] = 1'b0;
            if (misses_total != '1) misses_total++;
            if (store) begin
                line_dirty_q[k] = 1'b1;
                grow_held_dirty(bsize);
                r.dirtied = 1'b1;
            end
            was_valid = 1'b0;
        end else begin
            r.kind = MK_EVICT;
            way = 0;
            // oldest way wins, lowest index on a tie
            for (int i = 1; i < nw; i++)
                if (line_rank_q[base + i] > line_rank_q[base + way]) way = i;
            k = base + way;
            line_tag_q[k] = tag;
            if (misses_total != '1) misses_total++;
            if (evicts_total != '1) evicts_total++;
            if (line_dirty_q[k]) begin
                r.dev = 1'b1;
                held_dirty_total = (64'(held_dirty_total) > bsize)
                                 ? DBN_W'(64'(held_dirty_total) - bsize) : '0;
                sum = 64'(evicted_dirty_bytes) + bsize;
                evicted_dirty_bytes = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[DEB_W-1:0];
                line_dirty_q[k] = 1'b0;
            end
            if (store) begin
                line_dirty_q[k] = 1'b1;
                grow_held_dirty(bsize);
                r.dirtied = 1'b1;
            end
            was_valid = 1'b1;
        end
        // promote the touched way to most recent, age the ones it passes
        old_rank = line_rank_q[base + way];
        for (int i = 0; i < nw; i++) begin
            k = base + i;
            if (i != way && line_valid_q[k] && (!was_valid || line_rank_q[k] < old_rank)
                && line_rank_q[k] < RANK_MAX)
                line_rank_q[k]++;
        end
        line_rank_q[base + way] = '0;
        r.way = WAY_W'(way);
        r.hits = hits_total;
        r.misses = misses_total;
        r.evicts = evicts_total;
        r.dirty_now = held_dirty_total;
        r.dirty_out = evicted_dirty_bytes;
        return r;
    endfunction

    function automatic step_t acc(logic store, logic [ADDR_W-1:0] addr);
        step_t st;
        st = '{kind: MK_HIT, default: '0};
        st.store = store;
        st.addr = addr;
        return st;
    endfunction

    function automatic step_t acc_pin(logic store, logic [ADDR_W-1:0] addr, miss_kind_t kind,
                                      logic [WAY_W-1:0] way, logic dev, logic dirtied);
        step_t st;
        st = acc(store, addr);
        st.pinned = 1'b1;
        st.kind = kind;
        st.way = way;
        st.dev = dev;
        st.dirtied = dirtied;
        return st;
    endfunction

    function automatic step_t reg_wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        step_t st;
        st = acc(1'b0, '0);
        st.is_reg = 1'b1;
        st.idx = idx;
        st.val = val;
        return st;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg_write(idx, val);
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic send_access(step_t st);
        access_result_t r;
        cfg_valid <= 1'b0;
        s_tdata <= {{(S_TDATA_W - ADDR_W - 1){1'b0}}, st.addr, st.store};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = cache_lookup(st.store, st.addr);
        if (st.pinned) begin
            r.kind = st.kind;
            r.way = st.way;
            r.dev = st.dev;
            r.dirtied = st.dirtied;
        end
        pending_results.push_back(r);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // receiver stalls
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %0h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("miss_kind", 64'(want.kind), 64'(m_tdata[1:0]));
                check_field("way_used", 64'(want.way), 64'(m_tdata[4:2]));
                check_field("dirty_evicted", 64'(want.dev), 64'(m_tdata[5]));
                check_field("line_dirtied", 64'(want.dirtied), 64'(m_tdata[6]));
                check_field("hit_total", 64'(want.hits), 64'(m_tdata[38:7]));
                check_field("miss_total", 64'(want.misses), 64'(m_tdata[70:39]));
                check_field("eviction_total", 64'(want.evicts), 64'(m_tdata[102:71]));
                check_field("dirty_bytes_now", 64'(want.dirty_now), 64'(m_tdata[124:103]));
                check_field("dirty_evicted_bytes", 64'(want.dirty_out),
                            64'(m_tdata[172:125]));
            end
        end
    end

    initial begin : stimulus
        int unsigned sb, nw, bb, nsel, sidx;
        logic [ADDR_W-1:0] tag_base, tag, off, addr;
        step_t st;

        // single way, single set after reset
        directed_steps.push_back(acc_pin(1'b0, 64'd0, MK_COLD, 3'd0, 1'b0, 1'b0));
        directed_steps.push_back(acc_pin(1'b1, 64'd0, MK_HIT, 3'd0, 1'b0, 1'b1));
        directed_steps.push_back(acc_pin(1'b0, '1, MK_EVICT, 3'd0, 1'b1, 1'b0));
        directed_steps.push_back(acc_pin(1'b1, '1, MK_HIT, 3'd0, 1'b0, 1'b1));
        directed_steps.push_back(acc_pin(1'b1, 64'd1, MK_EVICT, 3'd0, 1'b1, 1'b1));
        directed_steps.push_back(reg_wr(CFG_NO_REG, 4'hF));
        directed_steps.push_back(acc_pin(1'b0, 64'd1, MK_HIT, 3'd0, 1'b0, 1'b0));
        // out-of-range values clamp to the largest geometry, lines kept
        directed_steps.push_back(reg_wr(CFG_SET_BITS, 4'd7));
        directed_steps.push_back(reg_wr(CFG_WAYS_USED, 4'd15));
        directed_steps.push_back(reg_wr(CFG_BLOCK_BITS, 4'd15));
        directed_steps.push_back(acc(1'b0, 64'd0));
        for (int k = 1; k <= 8; k++)
            directed_steps.push_back(acc(k[0], 64'(k) << 18));
        directed_steps.push_back(acc(1'b1, 64'd0));
        directed_steps.push_back(acc(1'b1, 64'h3_FFFF));
        directed_steps.push_back(reg_wr(CFG_WAYS_USED, 4'd0));
        directed_steps.push_back(reg_wr(CFG_SET_BITS, 4'd0));
        directed_steps.push_back(reg_wr(CFG_BLOCK_BITS, 4'd0));
        directed_steps.push_back(acc(1'b0, 64'h8000_0000_0000_0000));
        directed_steps.push_back(acc(1'b1, 64'h7FFF_FFFF_FFFF_FFFF));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            st = directed_steps[i];
            if (st.is_reg) begin
                write_reg(st.idx, st.val);
            end else begin
                idle_gap();
                send_access(st);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) calm = 1'b1;
            case (p)
                0: begin
                    write_reg(CFG_SET_BITS, 4'd6);
                    write_reg(CFG_WAYS_USED, 4'd8);
                    write_reg(CFG_BLOCK_BITS, 4'd0);
                end
                1: begin
                    write_reg(CFG_SET_BITS, 4'd0);
                    write_reg(CFG_WAYS_USED, 4'd1);
                    write_reg(CFG_BLOCK_BITS, 4'd12);
                end
                default: begin
                    if ($urandom_range(0, 2) != 0)
                        write_reg(CFG_SET_BITS, 4'($urandom_range(0, 15)));
                    if ($urandom_range(0, 2) != 0)
                        write_reg(CFG_WAYS_USED, 4'($urandom_range(0, 15)));
                    if ($urandom_range(0, 2) != 0)
                        write_reg(CFG_BLOCK_BITS, 4'($urandom_range(0, 15)));
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_NO_REG, 4'($urandom_range(0, 15)));
                end
            endcase
            tag_base = {$urandom, $urandom};
            eff_geometry(sb, nw, bb);
            nsel = ((1 << sb) - 1 > 3) ? 3 : (1 << sb) - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    addr = {$urandom, $urandom};
                end else begin
                    // small working set per set so lines both hit and get evicted
                    tag = tag_base + 64'($urandom_range(0, nw + 1));
                    sidx = $urandom_range(0, nsel);
                    off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
                    addr = (tag << (sb + bb)) | (64'(sidx) << bb) | off;
                end
                idle_gap();
                send_access(acc(1'($urandom_range(0, 1)), addr));
            end
        end

        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("set_assoc_lru_writeback_cache_model_unit: match");
        end else begin
            $display("set_assoc_lru_writeback_cache_model_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== set_assoc_lru_writeback_cache_model_unit.f =====
hdl/salwc_pkg.sv
hdl/set_assoc_lru_writeback_cache_model_unit.sv
dv/tb_top.sv
